>>> hdl/trapezoidal_step_pulse_generator_defines.svh
`ifndef TRAPEZOIDAL_STEP_PULSE_GENERATOR_DEFINES_SVH
`define TRAPEZOIDAL_STEP_PULSE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TSPG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TSPG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/tspg_pkg.sv
`timescale 1ns / 1ps

package tspg_pkg;

	localparam int RATE_W = 34;
	localparam int SC_W   = 33;
	localparam int EVT_W  = 33;
	localparam int RATIO_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [RATE_W-1:0] RATE_MAX = 34'h1_FFFF_FFFF;
	localparam logic [RATE_W-1:0] RATE_MIN = 34'h2_0000_0000;
	localparam logic [RATE_W-1:0] ONE_Q32  = 34'h1_0000_0000;
	localparam logic [RATE_W-1:0] ACC_MAX  = 34'h3_FFFF_FFFF;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 17'h1_0000;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_END   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECEL_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_RATE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_RATE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STEP  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO       = 3'd7;

	typedef struct packed {
		logic        mode;
		logic        move_dir;
		logic [31:0] step_total;
		logic [31:0] tick_number;
	} tspg_in_t;

	typedef struct packed {
		logic               step_pulse;
		logic               busy_res;
		logic               dir_out;
		logic signed [31:0] position;
	} tspg_out_t;

	// Profile settings as the core sees them; rates already scaled by the axis ratio.
	typedef struct packed {
		logic [31:0]     accel_end;
		logic [31:0]     decel_start;
		logic [31:0]     total;
		logic [SC_W-1:0] start_sc;
		logic [SC_W-1:0] peak_sc;
		logic [SC_W-1:0] accel_sc;
		logic [SC_W-1:0] decel_sc;
	} tspg_cfg_t;

	// (rate * ratio) >> 16; the result always fits in 33 bits.
	function automatic logic [SC_W-1:0] scale_rate(input logic [31:0] rate,
			input logic [RATIO_W-1:0] ratio);
		logic [48:0] prod;
		prod = {17'd0, rate} * {32'd0, ratio};
		return prod[48:16];
	endfunction

endpackage

>>> hdl/tspg_cfg.sv
`timescale 1ns / 1ps

module tspg_cfg
	import tspg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output tspg_cfg_t             cfg
);

	logic [31:0]        accel_end_q, decel_start_q, total_q;
	logic [31:0]        start_q, peak_q, accel_q, decel_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [SC_W-1:0]    start_sc_q, peak_sc_q, accel_sc_q, decel_sc_q;

	logic [31:0]        start_nxt, peak_nxt, accel_nxt, decel_nxt;
	logic [RATIO_W-1:0] ratio_nxt;

	always_comb begin
		start_nxt = start_q;
		peak_nxt  = peak_q;
		accel_nxt = accel_q;
		decel_nxt = decel_q;
		ratio_nxt = ratio_q;
		if (cfg_we) begin
			case (cfg_index)
				CFG_START_RATE: start_nxt = cfg_data;
				CFG_PEAK_RATE:  peak_nxt  = cfg_data;
				CFG_ACCEL_STEP: accel_nxt = cfg_data;
				CFG_DECEL_STEP: decel_nxt = cfg_data;
				CFG_RATIO:      ratio_nxt = cfg_data[RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_end_q   <= '0;
			decel_start_q <= '0;
			total_q       <= '0;
			start_q       <= '0;
			peak_q        <= '0;
			accel_q       <= '0;
			decel_q       <= '0;
			ratio_q       <= RATIO_RESET;
			start_sc_q    <= '0;
			peak_sc_q     <= '0;
			accel_sc_q    <= '0;
			decel_sc_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACCEL_END:   accel_end_q   <= cfg_data;
				CFG_DECEL_START: decel_start_q <= cfg_data;
				CFG_TOTAL:       total_q       <= cfg_data;
				default: ;
			endcase
			start_q <= start_nxt;
			peak_q  <= peak_nxt;
			accel_q <= accel_nxt;
			decel_q <= decel_nxt;
			ratio_q <= ratio_nxt;
			// rescale on every write so a ratio change reaches all four rates
			start_sc_q <= scale_rate(start_nxt, ratio_nxt);
			peak_sc_q  <= scale_rate(peak_nxt, ratio_nxt);
			accel_sc_q <= scale_rate(accel_nxt, ratio_nxt);
			decel_sc_q <= scale_rate(decel_nxt, ratio_nxt);
		end
	end

	assign cfg.accel_end   = accel_end_q;
	assign cfg.decel_start = decel_start_q;
	assign cfg.total       = total_q;
	assign cfg.start_sc    = start_sc_q;
	assign cfg.peak_sc     = peak_sc_q;
	assign cfg.accel_sc    = accel_sc_q;
	assign cfg.decel_sc    = decel_sc_q;

endmodule

>>> hdl/tspg_core.sv
`timescale 1ns / 1ps

module tspg_core
	import tspg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tspg_in_t  in_data,
	input  tspg_cfg_t cfg,
	input  logic      room,
	output logic      push,
	output tspg_out_t result
);

	tspg_in_t item_s1;
	logic     valid_s1;

	logic [RATE_W-1:0] rate_q, delta_q, acc_q;
	logic [EVT_W-1:0]  evt_q;
	logic [31:0]       done_q, goal_q, pos_q;
	logic              dir_q, running_q;

	logic [RATE_W-1:0] rate_nxt, delta_nxt, acc_nxt;
	logic [EVT_W-1:0]  evt_nxt;
	logic [31:0]       done_nxt, goal_nxt, pos_nxt;
	logic              dir_nxt, running_nxt, step;

	logic [RATE_W:0]   rate_sum, acc_sum;
	logic [RATE_W-1:0] rate_sat, rate_t, acc_base, acc_sat, neg_decel;
	logic [31:0]       tick, done_inc;
	logic              tick_hit, at_accel, at_decel, stepping;

	assign push     = valid_s1 && room;
	assign in_ready = !valid_s1 || push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		tick      = item_s1.tick_number;
		neg_decel = ~{1'b0, cfg.decel_sc} + 34'd1;

		// rate + delta, saturated to the 34-bit signed range
		rate_sum = {rate_q[RATE_W-1], rate_q} + {delta_q[RATE_W-1], delta_q};
		if (rate_sum[RATE_W] != rate_sum[RATE_W-1]) begin
			rate_sat = rate_sum[RATE_W] ? RATE_MIN : RATE_MAX;
		end else begin
			rate_sat = rate_sum[RATE_W-1:0];
		end

		tick_hit = ({1'b0, tick} == evt_q);
		at_accel = (tick == cfg.accel_end);
		at_decel = (tick == cfg.decel_start);

		rate_t  = rate_sat;
		delta_nxt = delta_q;
		evt_nxt = evt_q;
		if (tick_hit) begin
			if (at_accel) begin
				delta_nxt = '0;
				if (cfg.decel_start < cfg.total) begin
					evt_nxt = {1'b0, cfg.decel_start};
					if (!at_decel) begin
						rate_t = {1'b0, cfg.peak_sc};
					end
				end
			end
			if (at_decel) begin
				delta_nxt = neg_decel;
			end
		end

		// a rate at or below zero forces a step
		acc_base = acc_q;
		if (rate_t[RATE_W-1] || rate_t == '0) begin
			acc_base = ONE_Q32;
			rate_t   = '0;
		end
		acc_sum = {1'b0, acc_base} + {1'b0, rate_t};
		acc_sat = acc_sum[RATE_W] ? ACC_MAX : acc_sum[RATE_W-1:0];
		stepping = acc_sat[RATE_W-1] || acc_sat[RATE_W-2];
		done_inc = done_q + 32'd1;

		rate_nxt    = rate_t;
		acc_nxt     = stepping ? acc_sat - ONE_Q32 : acc_sat;
		done_nxt    = stepping ? done_inc : done_q;
		pos_nxt     = stepping ? pos_q + (dir_q ? 32'd1 : 32'hFFFF_FFFF) : pos_q;
		running_nxt = !(stepping && done_inc == goal_q);
		goal_nxt    = goal_q;
		dir_nxt     = dir_q;
		step        = stepping;

		if (item_s1.mode == MODE_START) begin
			dir_nxt     = item_s1.move_dir;
			goal_nxt    = item_s1.step_total;
			evt_nxt     = {1'b0, cfg.total} + 33'd1;
			delta_nxt   = '0;
			if (cfg.accel_end != '0) begin
				evt_nxt   = {1'b0, cfg.accel_end};
				delta_nxt = {1'b0, cfg.accel_sc};
			end else if (cfg.decel_start == '0) begin
				delta_nxt = neg_decel;
			end else if (cfg.decel_start != cfg.total) begin
				evt_nxt = {1'b0, cfg.decel_start};
			end
			rate_nxt    = {1'b0, cfg.start_sc};
			acc_nxt     = '0;
			done_nxt    = '0;
			pos_nxt     = pos_q;
			running_nxt = 1'b1;
			step        = 1'b0;
		end else if (!running_q) begin
			// tick while idle: hold everything
			rate_nxt    = rate_q;
			delta_nxt   = delta_q;
			acc_nxt     = acc_q;
			evt_nxt     = evt_q;
			done_nxt    = done_q;
			pos_nxt     = pos_q;
			running_nxt = 1'b0;
			step        = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= '0;
			delta_q   <= '0;
			acc_q     <= '0;
			evt_q     <= '0;
			done_q    <= '0;
			goal_q    <= '0;
			pos_q     <= '0;
			dir_q     <= 1'b0;
			running_q <= 1'b0;
		end else if (push) begin
			rate_q    <= rate_nxt;
			delta_q   <= delta_nxt;
			acc_q     <= acc_nxt;
			evt_q     <= evt_nxt;
			done_q    <= done_nxt;
			goal_q    <= goal_nxt;
			pos_q     <= pos_nxt;
			dir_q     <= dir_nxt;
			running_q <= running_nxt;
		end
	end

	assign result.step_pulse = step;
	assign result.busy_res   = running_nxt;
	assign result.dir_out    = dir_nxt;
	assign result.position   = pos_nxt;

endmodule

>>> hdl/tspg_outq.sv
`timescale 1ns / 1ps

module tspg_outq
	import tspg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tspg_out_t push_data,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output tspg_out_t out_data
);

	tspg_out_t  ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign room      = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> hdl/trapezoidal_step_pulse_generator.sv
`timescale 1ns / 1ps
// Trapezoidal step pulse generator, one axis.
// Input channel (in_valid/in_ready/in_data): a start word (mode 0) loads direction
// and step count and sets the starting rate; a tick word (mode 1) advances the
// velocity profile by one tick and may issue one step.
// Output channel (out_valid/out_ready/out_data): exactly one result word per input
// word, in order: step pulse, busy flag, direction pin and position.
// Configuration port (cfg_we/cfg_index/cfg_data): eight profile registers, which
// the user must write only while no word is in flight (the block does not enforce
// this); the rates are rescaled by the axis ratio as they are written.
// Flow: an accepted word is held in the input register, its result is computed from
// it and written into the result queue, and out_valid is raised from the queue.
// Throughput: one word per cycle while the result queue has room, set by the
// rate/accumulator update whose state feeds the next tick.
// Reset: profile state cleared, no move running, position zero, ratio 1.0, result
// queue empty.
// Receiver stall: a two-entry result queue and the input register keep taking
// words; with the queue full and the input register loaded, in_ready drops.

module trapezoidal_step_pulse_generator
	import tspg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tspg_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tspg_out_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	tspg_cfg_t cfg;
	tspg_out_t result;
	logic      room, push;

	tspg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tspg_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg),
		.room     (room),
		.push     (push),
		.result   (result)
	);

	tspg_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> hdl/tspg_checker.sv
`timescale 1ns / 1ps
`include "trapezoidal_step_pulse_generator_defines.svh"

module tspg_checker
	import tspg_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input tspg_out_t out_data
);

	logic signed [31:0] prev_pos_q;
	logic               out_take;

	assign out_take = out_valid && out_ready;

	// track the position of the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q <= '0;
		end else if (out_take) begin
			prev_pos_q <= out_data.position;
		end
	end

	`TSPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
	`TSPG_ASSERT_NOW(a_pos_still, out_take && !out_data.step_pulse, out_data.position == prev_pos_q, "position moved without a step")
	`TSPG_ASSERT_NOW(a_pos_fwd, out_take && out_data.step_pulse && out_data.dir_out, out_data.position == prev_pos_q + 32'sd1, "forward step did not add one")
	`TSPG_ASSERT_NOW(a_pos_rev, out_take && out_data.step_pulse && !out_data.dir_out, out_data.position == prev_pos_q - 32'sd1, "reverse step did not subtract one")

endmodule

bind trapezoidal_step_pulse_generator tspg_checker u_tspg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
